// ===== sv/brbs_pkg.sv =====
// Shared types and constants for the byte range block splitter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package brbs_pkg;

  // Field widths
  localparam int unsigned OFF_W      = 48;
  localparam int unsigned BLK_W      = 32;
  localparam int unsigned SZ_W       = 17;
  localparam int unsigned INOFF_W    = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Block size limits
  localparam logic [SZ_W-1:0] SZ_MAX   = 17'h10000;
  localparam logic [SZ_W-1:0] SZ_RESET = 17'd512;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_WHOLE = 2'd1,
    KIND_PREAD = 2'd2,
    KIND_PRMW  = 2'd3
  } kind_e;

  // Classified request, front end to back end
  typedef struct packed {
    logic             reject;
    logic             wr;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] fin;    // first byte past the clamped range
    logic [OFF_W-1:0] total;  // clamped byte count
  } job_t;

endpackage

`default_nettype wire

// ===== sv/brbs_if.sv =====
// Handshake interfaces of the byte range block splitter: request,
// command and configuration channels. Depends on brbs_pkg.
`default_nettype none

interface brbs_req_if;
  import brbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [OFF_W-1:0] byte_offset;
  logic [OFF_W-1:0] byte_count;
  modport source (output valid, func, byte_offset, byte_count, input ready);
  modport sink   (input valid, func, byte_offset, byte_count, output ready);
endinterface

interface brbs_cmd_if;
  import brbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BLK_W-1:0]   block_no;
  logic [BLK_W-1:0]   block_run;
  logic [INOFF_W-1:0] in_block_offset;
  logic [OFF_W-1:0]   length_bytes;
  logic [OFF_W-1:0]   buffer_offset;
  logic [OFF_W-1:0]   total_bytes;
  logic               last;
  modport source (output valid, kind, block_no, block_run, in_block_offset, length_bytes,
                  buffer_offset, total_bytes, last, input ready);
  modport sink   (input valid, kind, block_no, block_run, in_block_offset, length_bytes,
                  buffer_offset, total_bytes, last, output ready);
endinterface

interface brbs_cfg_if;
  import brbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/brbs_front.sv =====
// Front end: accepts request beats, computes device capacity, rejects and
// clamps requests. Two pipeline stages. Depends on brbs_pkg, brbs_if.
`default_nettype none

module brbs_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [brbs_pkg::SZ_W-1:0] blk_size_i,
  input  wire logic [brbs_pkg::BLK_W-1:0] blk_count_i,
  brbs_req_if.sink                       req_i,
  output brbs_pkg::job_t                 job_o,
  output logic                           job_valid_o,
  input  wire logic                      job_ready_i
);
  import brbs_pkg::*;

  logic             s1_v_q, s1_v_d;
  logic             s1_wr_q;
  logic [OFF_W-1:0] s1_off_q, s1_cnt_q;
  logic             s2_v_q, s2_v_d;
  logic             s2_wr_q;
  logic [OFF_W-1:0] s2_off_q, s2_cnt_q, s2_cap_q;

  logic             s1_ready, s2_ready;
  logic [OFF_W-1:0] cap_prod;
  logic [OFF_W-1:0] avail;
  logic             over;

  // Stall control
  assign s2_ready    = !s2_v_q || job_ready_i;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign req_i.ready = s1_ready;

  assign s1_v_d = s1_ready ? req_i.valid : s1_v_q;
  assign s2_v_d = s2_ready ? s1_v_q : s2_v_q;

  // Capacity; the product always fits 48 bits
  assign cap_prod = OFF_W'(blk_size_i) * OFF_W'(blk_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_wr_q  <= req_i.func;
      s1_off_q <= req_i.byte_offset;
      s1_cnt_q <= req_i.byte_count;
    end
    if (s2_ready) begin
      s2_wr_q  <= s1_wr_q;
      s2_off_q <= s1_off_q;
      s2_cnt_q <= s1_cnt_q;
      s2_cap_q <= cap_prod;
    end
  end

  // Reject and clamp against capacity
  assign avail = s2_cap_q - s2_off_q;
  assign over  = s2_cnt_q > avail;

  always_comb begin
    job_o.reject = (s2_cnt_q == '0) || (s2_off_q >= s2_cap_q);
    job_o.wr     = s2_wr_q;
    job_o.off    = s2_off_q;
    job_o.fin    = over ? s2_cap_q : s2_off_q + s2_cnt_q;
    job_o.total  = over ? avail : s2_cnt_q;
  end

  assign job_valid_o = s2_v_q;

endmodule

`default_nettype wire

// ===== sv/brbs_queue.sv =====
// Short queue of classified requests between front and back end.
// Depends on brbs_pkg.
`default_nettype none

module brbs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire brbs_pkg::job_t push_data_i,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  output brbs_pkg::job_t      pop_data_o,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i
);
  import brbs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/brbs_back.sv =====
// Back end: divides start and end byte addresses by the block size,
// plans head/whole/tail commands, or a none command for a rejected request,
// and emits them through an output register. Depends on brbs_pkg, brbs_if.
`default_nettype none

module brbs_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [brbs_pkg::SZ_W-1:0] blk_size_i,
  input  wire brbs_pkg::job_t            job_i,
  input  wire logic                      job_valid_i,
  output logic                           job_ready_o,
  brbs_cmd_if.source                     cmd_o
);
  import brbs_pkg::*;

  // Quotient bits resolved per cycle
  localparam int unsigned STEPS   = 2;
  localparam int unsigned DIV_CYC = BLK_W / STEPS;
  localparam int unsigned IT_W    = $clog2(DIV_CYC);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PLAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int unsigned P_HEAD = 0;
  localparam int unsigned P_MID  = 1;
  localparam int unsigned P_TAIL = 2;

  typedef struct packed {
    logic [SZ_W-1:0]  rem;
    logic [BLK_W-1:0] quo;
  } div_t;

  // One restoring division step; the dividend shifts out of quo as the
  // quotient shifts in
  function automatic div_t div_step(input div_t cur, input logic [SZ_W-1:0] dsr);
    logic [SZ_W:0] part;
    logic [SZ_W:0] diff;
    logic          ge;
    div_t          nxt;
    part     = {cur.rem, cur.quo[BLK_W-1]};
    diff     = part - {1'b0, dsr};
    ge       = part >= {1'b0, dsr};
    nxt.rem  = ge ? diff[SZ_W-1:0] : part[SZ_W-1:0];
    nxt.quo  = {cur.quo[BLK_W-2:0], ge};
    return nxt;
  endfunction

  logic [1:0]       state_q, state_d;
  job_t             job_q;
  div_t             da_q, da_d, db_q, db_d;
  logic [IT_W-1:0]  it_q, it_d;

  // Plan registers
  logic [2:0]       pend_q, pend_d;
  logic             none_q, none_d;
  logic [OFF_W-1:0] hd_len_q, md_len_q, md_buf_q, tl_buf_q;
  logic [BLK_W-1:0] md_blk_q, md_run_q;

  // Output register
  logic               out_v_q, out_v_d;
  logic [KIND_W-1:0]  o_kind_q, o_kind_d;
  logic [BLK_W-1:0]   o_blk_q, o_blk_d, o_run_q, o_run_d;
  logic [INOFF_W-1:0] o_inoff_q, o_inoff_d;
  logic [OFF_W-1:0]   o_len_q, o_len_d, o_buf_q, o_buf_d, o_tot_q, o_tot_d;
  logic               o_last_q, o_last_d;

  logic             pop, load_job, emit_go, emit_last;
  div_t             da_step, db_step;
  logic             has_head, head_only;
  logic [SZ_W-1:0]  room;
  logic [OFF_W-1:0] head_len, hl, tl_len;
  logic [BLK_W-1:0] start, run;
  logic [2:0]       pend_nxt;
  logic [KIND_W-1:0] part_kind;

  assign job_ready_o = state_q == ST_IDLE;
  assign pop         = job_valid_i && job_ready_o;
  assign load_job    = pop;

  // Divider datapath, both quotients in parallel
  always_comb begin
    da_step = da_q;
    db_step = db_q;
    for (int i = 0; i < STEPS; i++) begin
      da_step = div_step(da_step, blk_size_i);
      db_step = div_step(db_step, blk_size_i);
    end
  end

  // Plan: head, run of whole blocks, tail
  assign has_head  = da_q.rem != '0;
  assign room      = blk_size_i - da_q.rem;
  assign head_only = has_head && (job_q.total <= OFF_W'(room));
  assign head_len  = head_only ? job_q.total : OFF_W'(room);
  assign hl        = has_head ? head_len : '0;
  assign start     = has_head ? da_q.quo + 1'b1 : da_q.quo;
  assign run       = db_q.quo - start;
  assign tl_len    = OFF_W'(db_q.rem);
  assign part_kind = job_q.wr ? KIND_PRMW : KIND_PREAD;

  // Emit order: lowest pending bit first
  assign pend_nxt  = pend_q & (pend_q - 3'd1);
  assign emit_go   = (state_q == ST_EMIT) && (!out_v_q || cmd_o.ready);
  assign emit_last = none_q || (pend_nxt == '0);

  // Sequencer and next values
  always_comb begin
    state_d   = state_q;
    da_d      = da_q;
    db_d      = db_q;
    it_d      = it_q;
    pend_d    = pend_q;
    none_d    = none_q;
    out_v_d   = out_v_q;
    o_kind_d  = o_kind_q;
    o_blk_d   = o_blk_q;
    o_run_d   = o_run_q;
    o_inoff_d = o_inoff_q;
    o_len_d   = o_len_q;
    o_buf_d   = o_buf_q;
    o_tot_d   = o_tot_q;
    o_last_d  = o_last_q;

    if (out_v_q && cmd_o.ready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          da_d.rem = {1'b0, job_i.off[OFF_W-1:BLK_W]};
          da_d.quo = job_i.off[BLK_W-1:0];
          db_d.rem = {1'b0, job_i.fin[OFF_W-1:BLK_W]};
          db_d.quo = job_i.fin[BLK_W-1:0];
          it_d     = '0;
          state_d  = job_i.reject ? ST_PLAN : ST_DIV;
        end
      end
      ST_DIV: begin
        da_d = da_step;
        db_d = db_step;
        it_d = it_q + 1'b1;
        if (it_q == IT_W'(DIV_CYC - 1)) begin
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        none_d         = job_q.reject;
        pend_d[P_HEAD] = !job_q.reject && has_head;
        pend_d[P_MID]  = !job_q.reject && !head_only && (run != '0);
        pend_d[P_TAIL] = !job_q.reject && !head_only && (db_q.rem != '0);
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_v_d   = 1'b1;
          o_last_d  = emit_last;
          o_tot_d   = (emit_last && !none_q) ? job_q.total : '0;
          o_inoff_d = '0;
          if (none_q) begin
            o_kind_d = KIND_NONE;
            o_blk_d  = '0;
            o_run_d  = '0;
            o_len_d  = '0;
            o_buf_d  = '0;
            none_d   = 1'b0;
          end else if (pend_q[P_HEAD]) begin
            o_kind_d  = part_kind;
            o_blk_d   = da_q.quo;
            o_run_d   = BLK_W'(1);
            o_inoff_d = da_q.rem[INOFF_W-1:0];
            o_len_d   = hd_len_q;
            o_buf_d   = '0;
          end else if (pend_q[P_MID]) begin
            o_kind_d = KIND_WHOLE;
            o_blk_d  = md_blk_q;
            o_run_d  = md_run_q;
            o_len_d  = md_len_q;
            o_buf_d  = md_buf_q;
          end else begin
            o_kind_d = part_kind;
            o_blk_d  = db_q.quo;
            o_run_d  = BLK_W'(1);
            o_len_d  = tl_len;
            o_buf_d  = tl_buf_q;
          end
          pend_d = pend_nxt;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      none_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      none_q  <= none_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      job_q <= job_i;
    end
    da_q <= da_d;
    db_q <= db_d;
    it_q <= it_d;
    if (state_q == ST_PLAN) begin
      hd_len_q <= head_len;
      md_blk_q <= start;
      md_run_q <= run;
      md_len_q <= job_q.total - hl - tl_len;
      md_buf_q <= hl;
      tl_buf_q <= job_q.total - tl_len;
    end
    o_kind_q  <= o_kind_d;
    o_blk_q   <= o_blk_d;
    o_run_q   <= o_run_d;
    o_inoff_q <= o_inoff_d;
    o_len_q   <= o_len_d;
    o_buf_q   <= o_buf_d;
    o_tot_q   <= o_tot_d;
    o_last_q  <= o_last_d;
  end

  // Command channel
  assign cmd_o.valid           = out_v_q;
  assign cmd_o.kind            = o_kind_q;
  assign cmd_o.block_no        = o_blk_q;
  assign cmd_o.block_run       = o_run_q;
  assign cmd_o.in_block_offset = o_inoff_q;
  assign cmd_o.length_bytes    = o_len_q;
  assign cmd_o.buffer_offset   = o_buf_q;
  assign cmd_o.total_bytes     = o_tot_q;
  assign cmd_o.last            = o_last_q;

endmodule

`default_nettype wire

// ===== sv/byte_range_block_splitter_top.sv =====
// From request beat to first command valid: 2 front stages, queue pop, a
// divide at two quotient bits per cycle, plan, emit. The back end takes a new
// request only once it has emitted the last command of the previous one; a
// rejected request skips the divide. The front keeps taking requests into the
// queue meanwhile. Reset: block size 512, block count 0, queue and pipelines
// empty; the config channel is always ready.
`default_nettype none

module byte_range_block_splitter_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brbs_req_if.sink   req_i,
  brbs_cmd_if.source cmd_o,
  brbs_cfg_if.sink   cfg_i
);
  import brbs_pkg::*;

  logic [SZ_W-1:0]  blk_size_q;
  logic [BLK_W-1:0] blk_count_q;
  logic [SZ_W-1:0]  sz_eff;

  job_t fq_job, bq_job;
  logic fq_valid, fq_ready, bq_valid, bq_ready;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_size_q  <= SZ_RESET;
      blk_count_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_BLOCK_SIZE:  blk_size_q  <= cfg_i.data[SZ_W-1:0];
        CFG_BLOCK_COUNT: blk_count_q <= cfg_i.data[BLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Oversized block size acts as the maximum
  assign sz_eff = (blk_size_q > SZ_MAX) ? SZ_MAX : blk_size_q;

  brbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_size_i  (sz_eff),
    .blk_count_i (blk_count_q),
    .req_i       (req_i),
    .job_o       (fq_job),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready)
  );

  brbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (fq_job),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .pop_data_o   (bq_job),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready)
  );

  brbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_size_i  (sz_eff),
    .job_i       (bq_job),
    .job_valid_i (bq_valid),
    .job_ready_o (bq_ready),
    .cmd_o       (cmd_o)
  );

endmodule

`default_nettype wire
